// File: sv/rle_row_decoder_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the run-length row decoder
// Shared property wrappers, clocked on clk_i and held off while in reset.
// ----------------------------------------------------------------------------
`ifndef RLE_ROW_DECODER_MACROS_SVH
`define RLE_ROW_DECODER_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define RRD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define RRD_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/rrd_pkg.sv
// ----------------------------------------------------------------------------
// Run-length row decoder package
// Types, codes and constants shared by the decoder's front, back and top.
// ----------------------------------------------------------------------------
`default_nettype none

package rrd_pkg;

  localparam int unsigned ROW_COUNT_BITS_DEFAULT = 16;
  localparam int unsigned ROW_WIDTH_BITS         = 16;
  localparam int unsigned CFG_INDEX_BITS         = 8;
  localparam int unsigned CFG_DATA_BITS          = 16;
  localparam int unsigned RUN_BITS               = 7;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_WIDTH = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RLE_MODE  = 8'd1;

  // Header byte layout.
  localparam logic [7:0] HDR_COUNT_MASK  = 8'h7F;
  localparam logic [7:0] HDR_LITERAL_BIT = 8'h80;

  typedef enum logic [2:0] {
    PH_START,
    PH_HEADER,
    PH_LITERAL,
    PH_REPEAT,
    PH_SKIP
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LONG  = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_e;

  // One classified input byte on its way from front to back.
  typedef struct packed {
    logic [7:0]          data;
    logic                last;
    logic [RUN_BITS-1:0] count;
    logic                literal;
    logic                count_zero;
  } item_t;

  // One result held in the output queue.
  typedef struct packed {
    logic [7:0]          pixel;
    logic [RUN_BITS-1:0] repeat_res;
    logic                row_end;
    logic [1:0]          status;
  } result_t;

  // Handshake between front queue and back decoder.
  typedef struct packed {
    logic  valid;
    item_t item;
  } front_out_t;

endpackage

`default_nettype wire

// File: sv/rrd_front.sv
// ----------------------------------------------------------------------------
// Run-length row decoder front end
// Two-entry input queue that splits each byte into its header fields.
// ----------------------------------------------------------------------------
`default_nettype none

module rrd_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              last_byte_i,
  output rrd_pkg::front_out_t    front_o,
  input  wire logic              take_i
);

  rrd_pkg::item_t q_mem [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           do_push;
  rrd_pkg::item_t new_item;

  assign full    = (cnt_q == 2'd2);
  assign do_push = push && !full;

  always_comb begin
    new_item.data       = data_byte_i;
    new_item.last       = last_byte_i;
    new_item.count      = rrd_pkg::RUN_BITS'(data_byte_i & rrd_pkg::HDR_COUNT_MASK);
    new_item.literal    = (data_byte_i & rrd_pkg::HDR_LITERAL_BIT) != 8'd0;
    new_item.count_zero = (data_byte_i & rrd_pkg::HDR_COUNT_MASK) == 8'd0;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_ptr_q] <= new_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (take_i)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, take_i};
    end
  end

  assign front_o.valid = (cnt_q != 2'd0);
  assign front_o.item  = q_mem[rd_ptr_q];

endmodule

`default_nettype wire

// File: sv/rrd_back.sv
// ----------------------------------------------------------------------------
// Run-length row decoder back end
// Row decoding state machine and a two-entry result queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rle_row_decoder_macros.svh"

module rrd_back #(
  parameter int unsigned RowCountBits = rrd_pkg::ROW_COUNT_BITS_DEFAULT
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire rrd_pkg::front_out_t                front_i,
  output logic                                    take_o,
  input  wire logic [rrd_pkg::ROW_WIDTH_BITS-1:0] row_width_i,
  input  wire logic                               rle_mode_i,
  output logic                                    empty,
  input  wire logic                               pop,
  output rrd_pkg::result_t                        result_o
);

  localparam int unsigned RB = rrd_pkg::RUN_BITS;

  rrd_pkg::phase_e        phase_q, phase_d;
  logic [RB-1:0]          run_left_q, run_left_d;
  logic [RowCountBits-1:0] pixels_left_q, pixels_left_d;
  rrd_pkg::status_e       err_q, err_d;

  logic [RowCountBits-1:0] load_count;
  logic                    load_sat;
  logic                    res_valid;
  rrd_pkg::result_t        res;
  rrd_pkg::item_t          it;

  rrd_pkg::result_t oq_mem [2];
  logic             oq_wr_q, oq_rd_q;
  logic [1:0]       oq_cnt_q;
  logic             oq_push, oq_pop;

  logic             res_status_ok, res_repeat_ok;
  logic             row_closing, row_restarted;

  // Row width saturated to the counter width.
  assign load_sat   = ((32'(row_width_i) >> RowCountBits) != 32'd0);
  assign load_count = load_sat ? '1 : RowCountBits'(row_width_i);

  assign it     = front_i.item;
  assign take_o = front_i.valid && (oq_cnt_q != 2'd2);

  always_comb begin
    rrd_pkg::phase_e         ph;
    logic [RowCountBits-1:0] pl;
    logic                    emit;
    ph            = phase_q;
    pl            = pixels_left_q;
    emit          = 1'b0;
    run_left_d    = run_left_q;
    err_d         = err_q;
    res.pixel     = 8'd0;
    res.repeat_res = '0;
    if (phase_q == rrd_pkg::PH_START) begin
      pl = load_count;
      ph = rrd_pkg::PH_HEADER;
    end
    phase_d       = ph;
    pixels_left_d = pl;

    priority if (ph == rrd_pkg::PH_SKIP) begin
      // Bytes after an end marker or an error are dropped.
    end else if (!rle_mode_i) begin
      run_left_d = '0;
      phase_d    = rrd_pkg::PH_HEADER;
      if (pl == '0) begin
        if (err_d == rrd_pkg::ST_OK) err_d = rrd_pkg::ST_TOO_LONG;
        phase_d = rrd_pkg::PH_SKIP;
      end else begin
        pixels_left_d  = pl - RowCountBits'(1);
        emit           = 1'b1;
        res.pixel      = it.data;
        res.repeat_res = RB'(1);
        if (it.last && (pl != RowCountBits'(1)) && (err_d == rrd_pkg::ST_OK)) begin
          err_d = rrd_pkg::ST_TRUNCATED;
        end
      end
    end else begin
      unique case (ph)
        rrd_pkg::PH_HEADER: begin
          if (it.count_zero) begin
            phase_d = rrd_pkg::PH_SKIP;
          end else if (RowCountBits'(it.count) > pl) begin
            if (err_d == rrd_pkg::ST_OK) err_d = rrd_pkg::ST_TOO_LONG;
            phase_d = rrd_pkg::PH_SKIP;
          end else begin
            pixels_left_d = pl - RowCountBits'(it.count);
            run_left_d    = it.count;
            phase_d       = it.literal ? rrd_pkg::PH_LITERAL : rrd_pkg::PH_REPEAT;
            if (it.last && (err_d == rrd_pkg::ST_OK)) err_d = rrd_pkg::ST_TRUNCATED;
          end
        end
        rrd_pkg::PH_LITERAL: begin
          emit           = 1'b1;
          res.pixel      = it.data;
          res.repeat_res = RB'(1);
          run_left_d     = run_left_q - RB'(1);
          if (run_left_d == '0) begin
            phase_d = rrd_pkg::PH_HEADER;
          end else if (it.last && (err_d == rrd_pkg::ST_OK)) begin
            err_d = rrd_pkg::ST_TRUNCATED;
          end
        end
        rrd_pkg::PH_REPEAT: begin
          emit           = 1'b1;
          res.pixel      = it.data;
          res.repeat_res = run_left_q;
          run_left_d     = '0;
          phase_d        = rrd_pkg::PH_HEADER;
        end
        default: begin
          // Row start is folded into the header phase above.
        end
      endcase
    end

    res_valid   = emit || it.last;
    res.row_end = it.last;
    res.status  = it.last ? err_d : rrd_pkg::ST_OK;

    if (it.last) begin
      phase_d    = rrd_pkg::PH_START;
      run_left_d = '0;
      err_d      = rrd_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= rrd_pkg::PH_START;
      run_left_q    <= '0;
      pixels_left_q <= '0;
      err_q         <= rrd_pkg::ST_OK;
    end else if (take_o) begin
      phase_q       <= phase_d;
      run_left_q    <= run_left_d;
      pixels_left_q <= pixels_left_d;
      err_q         <= err_d;
    end
  end

  // Result queue.
  assign oq_push = take_o && res_valid;
  assign oq_pop  = pop && !empty;
  assign empty   = (oq_cnt_q == 2'd0);

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_mem[oq_wr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= 1'b0;
      oq_rd_q  <= 1'b0;
      oq_cnt_q <= 2'd0;
    end else begin
      if (oq_push) oq_wr_q <= ~oq_wr_q;
      if (oq_pop)  oq_rd_q <= ~oq_rd_q;
      oq_cnt_q <= oq_cnt_q + {1'b0, oq_push} - {1'b0, oq_pop};
    end
  end

  assign result_o = oq_mem[oq_rd_q];

  assign res_status_ok = empty || (result_o.status == rrd_pkg::ST_OK) || result_o.row_end;
  assign res_repeat_ok = empty || (result_o.repeat_res != '0) || result_o.row_end;
  assign row_closing   = take_o && it.last;
  assign row_restarted = (phase_q == rrd_pkg::PH_START) && (err_q == rrd_pkg::ST_OK);

  `RRD_ASSERT_ALWAYS(a_oq_bound, oq_cnt_q <= 2'd2, "Result queue count out of range")
  `RRD_ASSERT_ALWAYS(a_status_on_end, res_status_ok, "Error status away from the row end")
  `RRD_ASSERT_ALWAYS(a_zero_repeat_on_end, res_repeat_ok, "Empty result before the row end")
  `RRD_ASSERT_NEXT(a_row_restart, row_closing, row_restarted, "No row restart after last byte")

endmodule

`default_nettype wire

// File: sv/rle_row_decoder.sv
// ----------------------------------------------------------------------------
// Run-length row decoder
// Decodes one row of 8-bit run-length coded image data into pixel runs.
// ----------------------------------------------------------------------------
// The decoder takes one stored byte per transaction and sustains one byte
// per clock cycle while the result queue has room: the state machine does
// a fixed amount of work on small counters for every byte, and a two-entry
// queue on each side lets the input and the result side stall
// independently. A byte is registered in the input queue and its result
// in the result queue, from which it is on the result ports until it is
// taken. A header byte or an ignored
// byte that is not the row's last byte produces no result; every other
// byte produces exactly one. A repeat run comes out as one result whose
// repeat count is the run length, and the row's last byte always produces
// a result with row_end set that carries the row's status. Errors are
// sticky within a row and only the first is reported; pixels already
// delivered before an error stand. Configuration must only be written
// while the decoder is idle; row_width is sampled when a row starts and
// rle_mode is used for every byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_row_decoder #(
  parameter int unsigned RowCountBits = rrd_pkg::ROW_COUNT_BITS_DEFAULT
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Byte input, queue style.
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic [7:0]                         data_byte_i,
  input  wire logic                               last_byte_i,
  // Result output, queue style.
  output logic                                    empty,
  input  wire logic                               pop,
  output logic [7:0]                              pixel_o,
  output logic [rrd_pkg::RUN_BITS-1:0]            repeat_res_o,
  output logic                                    row_end_o,
  output logic [1:0]                              status_o,
  // Configuration write channel.
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [rrd_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  wire logic [rrd_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);

  logic [rrd_pkg::ROW_WIDTH_BITS-1:0] row_width_q;
  logic                               rle_mode_q;
  rrd_pkg::front_out_t                front;
  logic                               take;
  rrd_pkg::result_t                   result;

  // The register file never stalls a write.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= '0;
      rle_mode_q  <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        rrd_pkg::REG_ROW_WIDTH: row_width_q <= cfg_data_i[rrd_pkg::ROW_WIDTH_BITS-1:0];
        rrd_pkg::REG_RLE_MODE:  rle_mode_q  <= cfg_data_i[0];
        default: begin
          // Writes to unknown indexes are accepted and discarded.
        end
      endcase
    end
  end

  // The front end queues incoming bytes and splits out the header fields.
  rrd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .front_o     (front),
    .take_i      (take)
  );

  // The back end runs the row state machine and holds finished results.
  rrd_back #(
    .RowCountBits (RowCountBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .front_i     (front),
    .take_o      (take),
    .row_width_i (row_width_q),
    .rle_mode_i  (rle_mode_q),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result)
  );

  assign pixel_o      = result.pixel;
  assign repeat_res_o = result.repeat_res;
  assign row_end_o    = result.row_end;
  assign status_o     = result.status;

endmodule

`default_nettype wire

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the run-length row decoder
// Drives rows of stored bytes through the decoder and checks every pixel run
// and row status against an in-bench decoder that keeps its own row state.
// ----------------------------------------------------------------------------
// A directed table comes first: the rows after reset, the extremes of the
// row width, both decoding modes and each error. Where a result is plain to
// see, the table carries it; elsewhere the in-bench decoder supplies it. The
// random part then sends mostly well-formed coded and verbatim rows with
// random content, mixed with noise, truncated rows, stray headers and mode
// changes part-way through a row. Both sides idle at random, the result side
// once holds off long enough to fill the decoder, and configuration is only
// written once every expected transaction has come out.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned ITEM_TARGET  = 400;
  // Bytes pass through the input queue and the state machine; a byte that
  // yields no result can still be on its way when the last result appears.
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned MAX_ROW_BYTES   = 40;
  // An index the decoder does not implement; a write to it must be ignored.
  localparam logic [rrd_pkg::CFG_INDEX_BITS-1:0] REG_SPARE = 8'd2;

  typedef struct packed {
    logic                               is_cfg;
    logic [rrd_pkg::CFG_INDEX_BITS-1:0] reg_idx;
    logic [rrd_pkg::CFG_DATA_BITS-1:0]  value;
    logic                               last;
    logic                               typed;
    rrd_pkg::result_t                   want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                               byte_push   = 1'b0;
  logic                               in_full;
  logic [7:0]                         data_byte   = '0;
  logic                               last_byte   = 1'b0;
  logic                               res_empty;
  logic                               res_pop     = 1'b0;
  logic [7:0]                         pixel;
  logic [rrd_pkg::RUN_BITS-1:0]       repeat_res;
  logic                               row_end;
  logic [1:0]                         status;
  logic                               cfg_valid_i = 1'b0;
  logic                               cfg_ready_o;
  logic [rrd_pkg::CFG_INDEX_BITS-1:0] cfg_index_i = '0;
  logic [rrd_pkg::CFG_DATA_BITS-1:0]  cfg_data_i  = '0;

  rle_row_decoder uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (byte_push),
    .full         (in_full),
    .data_byte_i  (data_byte),
    .last_byte_i  (last_byte),
    .empty        (res_empty),
    .pop          (res_pop),
    .pixel_o      (pixel),
    .repeat_res_o (repeat_res),
    .row_end_o    (row_end),
    .status_o     (status),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Register copies as the decoder should hold them.
  logic [rrd_pkg::ROW_WIDTH_BITS-1:0] cfg_row_width = '0;
  logic                               cfg_rle_mode  = 1'b1;

  // Row state of the in-bench decoder, at its reset values.
  rrd_pkg::phase_e                            dec_phase    = rrd_pkg::PH_START;
  logic [rrd_pkg::RUN_BITS-1:0]               dec_run_left = '0;
  logic [rrd_pkg::ROW_COUNT_BITS_DEFAULT-1:0] dec_pix_left = '0;
  rrd_pkg::status_e                           dec_err      = rrd_pkg::ST_OK;

  // Pixel runs and row statuses still owed by the decoder, oldest first.
  rrd_pkg::result_t runs_due[$];
  logic [7:0]       row_q[$];
  int unsigned      items_decoded = 0;
  int unsigned      n_failures    = 0;
  bit               tx_burst      = 1'b0;
  bit               rx_burst      = 1'b0;

  // Each row below is either a register write or one stored byte. Rows with
  // typed set carry their result; the others rely on the in-bench decoder.
  stim_row_t directed_rows [31] = '{
    // Straight after reset the row width is zero, so any run is too long.
    '{1'b0, '0, 16'h0081, 1'b0, 1'b0, '0},
    '{1'b0, '0, 16'h00FF, 1'b1, 1'b1, '{8'h00, 7'd0, 1'b1, rrd_pkg::ST_TOO_LONG}},
    '{1'b1, rrd_pkg::REG_ROW_WIDTH, 16'd10, 1'b0, 1'b0, '0},
    // Repeat run, literal run, end-of-row marker and an ignored byte.
    '{1'b0, '0, 16'h0003, 1'b0, 1'b0, '0},
    '{1'b0, '0, 16'h00FF, 1'b0, 1'b1, '{8'hFF, 7'd3, 1'b0, rrd_pkg::ST_OK}},
    '{1'b0, '0, 16'h0082, 1'b0, 1'b0, '0},
    '{1'b0, '0, 16'h0000, 1'b0, 1'b1, '{8'h00, 7'd1, 1'b0, rrd_pkg::ST_OK}},
    '{1'b0, '0, 16'h00AB, 1'b0, 1'b1, '{8'hAB, 7'd1, 1'b0, rrd_pkg::ST_OK}},
    '{1'b0, '0, 16'h0000, 1'b0, 1'b0, '0},
    '{1'b0, '0, 16'h0055, 1'b0, 1'b0, '0},
    '{1'b0, '0, 16'h0011, 1'b1, 1'b1, '{8'h00, 7'd0, 1'b1, rrd_pkg::ST_OK}},
    // A literal run cut short by the last byte.
    '{1'b0, '0, 16'h0084, 1'b0, 1'b0, '0},
    '{1'b0, '0, 16'h0012, 1'b0, 1'b1, '{8'h12, 7'd1, 1'b0, rrd_pkg::ST_OK}},
    '{1'b0, '0, 16'h0034, 1'b1, 1'b1, '{8'h34, 7'd1, 1'b1, rrd_pkg::ST_TRUNCATED}},
    // A header that is itself the last byte.
    '{1'b0, '0, 16'h0005, 1'b1, 1'b1, '{8'h00, 7'd0, 1'b1, rrd_pkg::ST_TRUNCATED}},
    // One pixel more than the row holds.
    '{1'b0, '0, 16'h000B, 1'b0, 1'b0, '0},
    '{1'b0, '0, 16'h0000, 1'b1, 1'b1, '{8'h00, 7'd0, 1'b1, rrd_pkg::ST_TOO_LONG}},
    // Widest row and the longest repeat run.
    '{1'b1, rrd_pkg::REG_ROW_WIDTH, 16'hFFFF, 1'b0, 1'b0, '0},
    '{1'b0, '0, 16'h007F, 1'b0, 1'b0, '0},
    '{1'b0, '0, 16'h0080, 1'b0, 1'b1, '{8'h80, 7'd127, 1'b0, rrd_pkg::ST_OK}},
    '{1'b0, '0, 16'h0000, 1'b1, 1'b1, '{8'h00, 7'd0, 1'b1, rrd_pkg::ST_OK}},
    // Verbatim rows of two pixels: exact, short and overlong.
    '{1'b1, rrd_pkg::REG_RLE_MODE, 16'd0, 1'b0, 1'b0, '0},
    '{1'b1, rrd_pkg::REG_ROW_WIDTH, 16'd2, 1'b0, 1'b0, '0},
    '{1'b0, '0, 16'h00A5, 1'b0, 1'b1, '{8'hA5, 7'd1, 1'b0, rrd_pkg::ST_OK}},
    '{1'b0, '0, 16'h005A, 1'b1, 1'b1, '{8'h5A, 7'd1, 1'b1, rrd_pkg::ST_OK}},
    '{1'b0, '0, 16'h0001, 1'b1, 1'b1, '{8'h01, 7'd1, 1'b1, rrd_pkg::ST_TRUNCATED}},
    '{1'b1, REG_SPARE, 16'hFFFF, 1'b0, 1'b0, '0},
    '{1'b0, '0, 16'h0010, 1'b0, 1'b1, '{8'h10, 7'd1, 1'b0, rrd_pkg::ST_OK}},
    '{1'b0, '0, 16'h0020, 1'b0, 1'b1, '{8'h20, 7'd1, 1'b0, rrd_pkg::ST_OK}},
    '{1'b0, '0, 16'h0030, 1'b1, 1'b1, '{8'h00, 7'd0, 1'b1, rrd_pkg::ST_TOO_LONG}},
    '{1'b1, rrd_pkg::REG_RLE_MODE, 16'd1, 1'b0, 1'b0, '0}
  };

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Only the first error of a row is kept.
  function automatic void flag_error(input rrd_pkg::status_e code);
    if (dec_err == rrd_pkg::ST_OK) dec_err = code;
  endfunction

  // Steps the in-bench decoder by one stored byte. Returns 1 when the byte
  // yields a result, which is then left in res.
  function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                     output rrd_pkg::result_t res);
    logic [rrd_pkg::RUN_BITS-1:0] cnt;
    bit                           emit;
    cnt  = rrd_pkg::RUN_BITS'(b & rrd_pkg::HDR_COUNT_MASK);
    emit = 1'b0;
    res  = '0;
    if (dec_phase == rrd_pkg::PH_START) begin
      dec_pix_left = cfg_row_width;
      dec_phase    = rrd_pkg::PH_HEADER;
    end
    if (dec_phase == rrd_pkg::PH_SKIP) begin
      // Ignored until the row's last byte, whatever the mode.
    end else if (!cfg_rle_mode) begin
      // Verbatim: any coded run still pending is dropped.
      dec_run_left = '0;
      dec_phase    = rrd_pkg::PH_HEADER;
      if (dec_pix_left == 0) begin
        flag_error(rrd_pkg::ST_TOO_LONG);
        dec_phase = rrd_pkg::PH_SKIP;
      end else begin
        dec_pix_left   = dec_pix_left - 1'b1;
        emit           = 1'b1;
        res.pixel      = b;
        res.repeat_res = 7'd1;
        if (last && dec_pix_left != 0) flag_error(rrd_pkg::ST_TRUNCATED);
      end
    end else if (dec_phase == rrd_pkg::PH_HEADER) begin
      if (cnt == 0) begin
        dec_phase = rrd_pkg::PH_SKIP;
      end else if (cnt > dec_pix_left) begin
        flag_error(rrd_pkg::ST_TOO_LONG);
        dec_phase = rrd_pkg::PH_SKIP;
      end else begin
        dec_pix_left = dec_pix_left - cnt;
        dec_run_left = cnt;
        if ((b & rrd_pkg::HDR_LITERAL_BIT) != 0) dec_phase = rrd_pkg::PH_LITERAL;
        else dec_phase = rrd_pkg::PH_REPEAT;
        if (last) flag_error(rrd_pkg::ST_TRUNCATED);
      end
    end else if (dec_phase == rrd_pkg::PH_LITERAL) begin
      emit           = 1'b1;
      res.pixel      = b;
      res.repeat_res = 7'd1;
      dec_run_left   = dec_run_left - 1'b1;
      if (dec_run_left == 0) dec_phase = rrd_pkg::PH_HEADER;
      else if (last) flag_error(rrd_pkg::ST_TRUNCATED);
    end else begin
      // The value byte of a repeat run carries the whole run in one result.
      emit           = 1'b1;
      res.pixel      = b;
      res.repeat_res = dec_run_left;
      dec_run_left   = '0;
      dec_phase      = rrd_pkg::PH_HEADER;
    end
    if (!emit && !last) return 1'b0;
    res.row_end = last;
    res.status  = last ? dec_err : rrd_pkg::ST_OK;
    if (last) begin
      dec_phase    = rrd_pkg::PH_START;
      dec_run_left = '0;
      dec_err      = rrd_pkg::ST_OK;
    end
    return 1'b1;
  endfunction

  // Presents one byte and holds it until the input transaction completes.
  // A typed result from the directed table replaces the decoded one, but the
  // in-bench decoder still steps so that its row state stays in line.
  task automatic send_byte(input logic [7:0] b, input logic last,
                           input logic typed, input rrd_pkg::result_t want);
    rrd_pkg::result_t res;
    bit               counted;
    byte_push <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    do @(posedge clk_i); while (in_full !== 1'b0);
    counted = (dec_phase != rrd_pkg::PH_SKIP);
    if (decode_byte(b, last, res)) runs_due.push_back(typed ? want : res);
    if (counted) items_decoded++;
  endtask

  task automatic idle_for(input int unsigned n);
    if (n > 0) begin
      byte_push <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Mostly back to back, sometimes a short gap, now and then a long one.
  function automatic int unsigned sender_gap();
    int unsigned r;
    if (tx_burst) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Waits for every owed transaction, then lets the pipeline empty of bytes
  // that produce nothing.
  task automatic wait_drained();
    while (runs_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [rrd_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [rrd_pkg::CFG_DATA_BITS-1:0] value);
    byte_push <= 1'b0;
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    case (idx)
      rrd_pkg::REG_ROW_WIDTH: cfg_row_width = value;
      rrd_pkg::REG_RLE_MODE:  cfg_rle_mode  = value[0];
      default: ;
    endcase
  endtask

  // Fills row_q with the stored bytes of one row. Most rows are well formed
  // for the current mode and width; the rest are noise, are one byte too long
  // or are broken by truncation or a stray header.
  task automatic build_row();
    int unsigned flavour;
    int unsigned cnt;
    int unsigned top;
    int          left;
    flavour = $urandom_range(0, 9);
    row_q.delete();
    if (flavour == 0) begin
      repeat ($urandom_range(1, 12)) row_q.push_back(8'($urandom));
    end else if (!cfg_rle_mode) begin
      left = (cfg_row_width > MAX_ROW_BYTES) ? MAX_ROW_BYTES : cfg_row_width;
      if (flavour == 1) left = left + 1;
      else if (flavour == 2 && left > 1) left = left - 1;
      if (left == 0) left = 1;
      repeat (left) row_q.push_back(8'($urandom));
    end else begin
      left = cfg_row_width;
      while (left > 0 && row_q.size() < MAX_ROW_BYTES) begin
        top = (left > 127) ? 127 : left;
        cnt = $urandom_range(1, top);
        if ($urandom_range(0, 1)) begin
          if (cnt > 6) cnt = $urandom_range(1, 6);
          row_q.push_back(rrd_pkg::HDR_LITERAL_BIT | 8'(cnt));
          repeat (cnt) row_q.push_back(8'($urandom));
        end else begin
          row_q.push_back(8'(cnt));
          row_q.push_back(8'($urandom));
        end
        left = left - cnt;
      end
      // Close a row that is not yet full with a zero-count header, which may
      // be followed by bytes the decoder must ignore.
      if (left > 0 || row_q.size() == 0 || $urandom_range(0, 3) == 0) begin
        row_q.push_back($urandom_range(0, 1) ? rrd_pkg::HDR_LITERAL_BIT : 8'h00);
        repeat ($urandom_range(0, 3)) row_q.push_back(8'($urandom));
      end
      if (flavour == 1) begin
        cnt = $urandom_range(1, row_q.size());
        while (row_q.size() > cnt) void'(row_q.pop_back());
      end else if (flavour == 2) begin
        row_q.insert($urandom_range(0, row_q.size() - 1), 8'($urandom));
      end
    end
  endtask

  // Result side: checks each output transaction and decides pop for the
  // next cycle. Once, well into the run, it holds off for a long stretch
  // while bytes keep coming, so that both queues fill and full rises.
  initial begin : result_side
    int unsigned      stall;
    bit               held_off;
    rrd_pkg::result_t got;
    rrd_pkg::result_t want;
    stall    = 0;
    held_off = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (res_pop && res_empty === 1'b0) begin
        got = '{pixel, repeat_res, row_end, status};
        if (runs_due.size() == 0) begin
          $display("%0t: result with nothing expected: pixel %h repeat %0d end %b status %0d",
                   $time, got.pixel, got.repeat_res, got.row_end, got.status);
          n_failures++;
        end else begin
          want = runs_due.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch, expected pixel %h repeat %0d end %b status %0d",
                     $time, want.pixel, want.repeat_res, want.row_end, want.status);
            $display("%0t:          actual   pixel %h repeat %0d end %b status %0d",
                     $time, got.pixel, got.repeat_res, got.row_end, got.status);
            n_failures++;
          end
        end
      end
      if (!held_off && items_decoded >= 150) begin
        held_off = 1'b1;
        stall    = HOLD_OFF_CYCLES;
      end
      if ($urandom_range(0, 63) == 0) rx_burst = ~rx_burst;
      if (stall > 0) begin
        stall--;
        res_pop <= 1'b0;
      end else begin
        res_pop <= 1'b1;
        if (!rx_burst && $urandom_range(0, 5) == 0)
          stall = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      end
    end
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("FAIL rle_row_decoder");
    $finish;
  end

  initial begin : byte_side
    int unsigned                       r;
    int                                split;
    bit                                paused;
    logic [rrd_pkg::CFG_DATA_BITS-1:0] value;
    paused = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        send_byte(directed_rows[i].value[7:0], directed_rows[i].last,
                  directed_rows[i].typed, directed_rows[i].want);
        idle_for(sender_gap());
      end
    end

    while (items_decoded < ITEM_TARGET) begin
      // New settings for a group of rows, including the width extremes.
      r = $urandom_range(0, 9);
      if (r == 0) value = '0;
      else if (r == 1) value = '1;
      else if (r == 2) value = rrd_pkg::CFG_DATA_BITS'($urandom_range(25, 3000));
      else value = rrd_pkg::CFG_DATA_BITS'($urandom_range(1, 24));
      write_reg(rrd_pkg::REG_ROW_WIDTH, value);
      if ($urandom_range(0, 2) == 0) begin
        value    = rrd_pkg::CFG_DATA_BITS'($urandom);
        value[0] = ($urandom_range(0, 3) != 0);
        write_reg(rrd_pkg::REG_RLE_MODE, value);
      end
      if ($urandom_range(0, 9) == 0) begin
        write_reg(REG_SPARE, rrd_pkg::CFG_DATA_BITS'($urandom));
      end

      repeat ($urandom_range(1, 4)) begin
        build_row();
        tx_burst = ($urandom_range(0, 3) == 0);
        // Now and then the mode flips part-way through a row.
        split = -1;
        if (row_q.size() > 1 && $urandom_range(0, 19) == 0)
          split = $urandom_range(1, row_q.size() - 1);
        foreach (row_q[i]) begin
          if (i == split) begin
            value    = rrd_pkg::CFG_DATA_BITS'($urandom);
            value[0] = ~cfg_rle_mode;
            write_reg(rrd_pkg::REG_RLE_MODE, value);
          end
          send_byte(row_q[i], i == row_q.size() - 1, 1'b0, '0);
          idle_for(sender_gap());
        end
      end

      // Once, the byte side stops until the decoder has delivered everything.
      if (!paused && items_decoded >= 250) begin
        paused = 1'b1;
        byte_push <= 1'b0;
        wait_drained();
      end
    end

    byte_push <= 1'b0;
    wait_drained();
    repeat (4 * DRAIN_CYCLES) @(posedge clk_i);
    if (n_failures == 0 && runs_due.size() == 0) begin
      $display("PASS rle_row_decoder");
    end else begin
      $display("FAIL rle_row_decoder");
    end
    $finish;
  end

endmodule

`default_nettype wire
